@@ src/mtd_pkg.sv @@
// Package with shared constants, types and the Morse lookup for the tone decoder.
package mtd_pkg;

    localparam int unsigned TEXT_LIMIT   = 256;
    localparam int unsigned SYMBOL_LIMIT = 31;
    localparam int unsigned TEXT_W       = $clog2(TEXT_LIMIT + 1);

    localparam logic [15:0] ALPHA_Q16 = 16'd6554;
    localparam logic [15:0] BETA_Q16  = 16'd58982;

    localparam logic [2:0] CFG_SPD = 3'd0;
    localparam logic [2:0] CFG_THR = 3'd1;
    localparam logic [2:0] CFG_B0  = 3'd2;
    localparam logic [2:0] CFG_A1  = 3'd3;
    localparam logic [2:0] CFG_A2  = 3'd4;

    localparam logic [6:0] CH_QUEST = 7'h3F;
    localparam logic [6:0] CH_SPACE = 7'h20;

    typedef struct packed {
        logic load_x;
        logic mac;
        logic finish;
        logic clear;
    } mtd_cmd_t;

    typedef struct packed {
        logic       has_char;
        logic [6:0] char_code;
        logic       has_space;
    } mtd_stat_t;

    // Map symbol count (1..6) and dash bits to ASCII.
    function automatic logic [6:0] morse_lookup(input logic [2:0] cnt, input logic [5:0] bits);
        logic [6:0] c;
        c = CH_QUEST;
        unique case (cnt)
            3'd1:
            begin
                case (bits[0])
                    1'b0: c = 7'h45;
                    default: c = 7'h54;
                endcase
            end
            3'd2:
            begin
                case (bits[1:0])
                    2'b10: c = 7'h41;
                    2'b00: c = 7'h49;
                    2'b11: c = 7'h4D;
                    default: c = 7'h4E;
                endcase
            end
            3'd3:
            begin
                case (bits[2:0])
                    3'b001: c = 7'h44;
                    3'b011: c = 7'h47;
                    3'b101: c = 7'h4B;
                    3'b111: c = 7'h4F;
                    3'b010: c = 7'h52;
                    3'b000: c = 7'h53;
                    3'b100: c = 7'h55;
                    default: c = 7'h57;
                endcase
            end
            3'd4:
            begin
                case (bits[3:0])
                    4'b0001: c = 7'h42;
                    4'b0101: c = 7'h43;
                    4'b0100: c = 7'h46;
                    4'b0000: c = 7'h48;
                    4'b1110: c = 7'h4A;
                    4'b0010: c = 7'h4C;
                    4'b0110: c = 7'h50;
                    4'b1011: c = 7'h51;
                    4'b1000: c = 7'h56;
                    4'b1001: c = 7'h58;
                    4'b1101: c = 7'h59;
                    4'b0011: c = 7'h5A;
                    default: c = CH_QUEST;
                endcase
            end
            3'd5:
            begin
                case (bits[4:0])
                    5'b11111: c = 7'h30;
                    5'b11110: c = 7'h31;
                    5'b11100: c = 7'h32;
                    5'b11000: c = 7'h33;
                    5'b10000: c = 7'h34;
                    5'b00000: c = 7'h35;
                    5'b00001: c = 7'h36;
                    5'b00011: c = 7'h37;
                    5'b00111: c = 7'h38;
                    5'b01111: c = 7'h39;
                    5'b01001: c = 7'h2F;
                    5'b01101: c = 7'h28;
                    5'b10001: c = 7'h3D;
                    5'b01010: c = 7'h2B;
                    default: c = CH_QUEST;
                endcase
            end
            3'd6:
            begin
                case (bits)
                    6'b101010: c = 7'h2E;
                    6'b110011: c = 7'h2C;
                    6'b001100: c = 7'h3F;
                    6'b011110: c = 7'h27;
                    6'b110101: c = 7'h21;
                    6'b100001: c = 7'h2D;
                    6'b010010: c = 7'h22;
                    6'b010110: c = 7'h40;
                    default: c = CH_QUEST;
                endcase
            end
            default: c = CH_QUEST;
        endcase
        return c;
    endfunction

endpackage

@@ src/morse_tone_decoder.sv @@
// Morse tone decoder top level: config registers, controller and datapath.
// A sample steps through the MAC, FIN and EVAL states before a character or space is sent.
// A new sample waits until the last one and its character or space are issued.
// Four MAC steps share one multiplier; a result waits while the output is held.
// rst_n clears the filter history, timing and text state and loads register defaults.
module morse_tone_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // sample
    input  logic        s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // char_code, zero pad
    output logic        m_tlast,  // last
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [17:0] cfg_data
);

    logic [15:0] spd_reg;
    logic [14:0] thr_reg;
    logic [17:0] b0_reg, a1_reg, a2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spd_reg <= 16'd640;
            thr_reg <= 15'd500;
            b0_reg  <= 18'd10243;
            a1_reg  <= 18'(-91955);
            a2_reg  <= 18'd45056;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mtd_pkg::CFG_SPD: spd_reg <= cfg_data[15:0];
                mtd_pkg::CFG_THR: thr_reg <= cfg_data[14:0];
                mtd_pkg::CFG_B0:  b0_reg  <= cfg_data;
                mtd_pkg::CFG_A1:  a1_reg  <= cfg_data;
                mtd_pkg::CFG_A2:  a2_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    mtd_pkg::mtd_cmd_t  cmd;
    mtd_pkg::mtd_stat_t stat;
    logic [1:0] mac_sel;
    logic [6:0] code;

    mtd_control u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_kind(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_code(code), .m_last(m_tlast),
        .cmd(cmd), .mac_sel(mac_sel), .stat(stat)
    );

    mtd_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .mac_sel(mac_sel),
        .sample(s_tdata), .samples_per_dot(spd_reg), .envelope_threshold(thr_reg),
        .gain_b0(b0_reg), .feedback_a1(a1_reg), .feedback_a2(a2_reg),
        .stat(stat)
    );

    assign m_tdata = {1'b0, code};

endmodule

@@ src/mtd_datapath.sv @@
// Datapath: biquad MAC, envelope, threshold, timing counters and symbol state.
module mtd_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mtd_pkg::mtd_cmd_t    cmd,
    input  logic [1:0]           mac_sel,
    input  logic signed [15:0]   sample,
    input  logic [15:0]          samples_per_dot,
    input  logic [14:0]          envelope_threshold,
    input  logic signed [17:0]   gain_b0,
    input  logic signed [17:0]   feedback_a1,
    input  logic signed [17:0]   feedback_a2,
    output mtd_pkg::mtd_stat_t   stat
);

    logic signed [15:0] x_reg, x1_reg, x2_reg;
    logic signed [23:0] y1_reg, y2_reg;
    logic signed [47:0] acc_reg, acc_next;
    logic [31:0] env_reg;
    logic tone_reg;
    logic [31:0] mark_reg, gap_reg;
    logic [4:0]  scnt_reg;
    logic [5:0]  sbits_reg;

    logic signed [18:0] coef;
    logic signed [24:0] opnd;
    logic signed [43:0] prod;

    always_comb
    begin
        unique case (mac_sel)
            2'd0: begin coef = 19'(gain_b0); opnd = 25'(x_reg); end
            2'd1: begin coef = -19'(gain_b0); opnd = 25'(x2_reg); end
            2'd2: begin coef = -19'(feedback_a1); opnd = 25'(y1_reg); end
            default: begin coef = -19'(feedback_a2); opnd = 25'(y2_reg); end
        endcase
        prod = coef * opnd;
        acc_next = (mac_sel == 2'd0) ? 48'(prod) : acc_reg + 48'(prod);
    end

    // Round half up then saturate.
    logic signed [47:0] rnd;
    logic signed [31:0] q;
    logic signed [23:0] y;
    logic [23:0] mag;
    logic [47:0] env_sum;
    logic [31:0] env_new;
    logic above;
    logic [18:0] spd2;
    logic [18:0] spd3;
    logic [18:0] spd7;
    logic dash;
    logic onset;
    logic char_end;
    logic [6:0] look;
    mtd_pkg::mtd_stat_t stat_next;

    always_comb
    begin
        rnd = acc_reg + 48'sd32768;
        q   = 32'(rnd >>> 16);
        if (q > 32'sd8388607)
            y = 24'sh7FFFFF;
        else if (q < -32'sd8388608)
            y = 24'sh800000;
        else
            y = q[23:0];
        mag = y[23] ? 24'(-y) : 24'(y);
        env_sum = 48'(mtd_pkg::ALPHA_Q16) * 48'({mag, 8'd0})
                + 48'(mtd_pkg::BETA_Q16) * 48'(env_reg) + 48'd32768;
        env_new = env_sum[47:16];
        above = env_new > {9'd0, envelope_threshold, 8'd0};
        spd2 = {2'd0, samples_per_dot, 1'b0};
        spd3 = 19'(samples_per_dot) * 19'd3;
        spd7 = 19'(samples_per_dot) * 19'd7;
        dash = !(mark_reg < 32'(spd2));
        onset = above && !tone_reg;
        char_end = onset && (gap_reg > 32'(spd3));
        stat_next.has_char = char_end && (scnt_reg != 5'd0);
        stat_next.char_code = look;
        stat_next.has_space = onset && (gap_reg > 32'(spd7));
    end

    always_comb
    begin
        look = (scnt_reg > 5'd6) ? mtd_pkg::CH_QUEST
                                 : mtd_pkg::morse_lookup(scnt_reg[2:0], sbits_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
            x_reg <= sample;
        if (cmd.mac)
            acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0; x2_reg <= '0; y1_reg <= '0; y2_reg <= '0;
            env_reg <= '0; tone_reg <= 1'b0; mark_reg <= '0; gap_reg <= '0;
            scnt_reg <= '0; sbits_reg <= '0;
            stat <= '0;
        end
        else if (cmd.clear)
        begin
            tone_reg <= 1'b0; scnt_reg <= '0; sbits_reg <= '0;
            stat <= '0;
        end
        else if (cmd.finish)
        begin
            x2_reg <= x1_reg; x1_reg <= x_reg;
            y2_reg <= y1_reg; y1_reg <= y;
            env_reg <= env_new;
            stat <= stat_next;
            if (onset)
            begin
                if (stat_next.has_char)
                begin
                    scnt_reg <= '0;
                    sbits_reg <= '0;
                end
                tone_reg <= 1'b1;
                mark_reg <= 32'd1;
                gap_reg <= '0;
            end
            else if (!above && tone_reg)
            begin
                tone_reg <= 1'b0;
                if (scnt_reg < 5'(mtd_pkg::SYMBOL_LIMIT))
                begin
                    if (dash && scnt_reg < 5'd6)
                        sbits_reg[scnt_reg[2:0]] <= 1'b1;
                    scnt_reg <= scnt_reg + 5'd1;
                end
            end
            else if (above)
            begin
                if (mark_reg != 32'hFFFF_FFFF)
                    mark_reg <= mark_reg + 32'd1;
            end
            else
            begin
                if (gap_reg != 32'hFFFF_FFFF)
                    gap_reg <= gap_reg + 32'd1;
            end
        end
    end

endmodule

@@ src/mtd_control.sv @@
// Controller: sequences the MAC steps and emits decoded characters and spaces.
module mtd_control (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_kind,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [6:0]         m_code,
    output logic               m_last,
    output mtd_pkg::mtd_cmd_t  cmd,
    output logic [1:0]         mac_sel,
    input  mtd_pkg::mtd_stat_t stat
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MAC   = 6'b000010,
        S_FIN   = 6'b000100,
        S_EVAL  = 6'b001000,
        S_CHAR  = 6'b010000,
        S_SPACE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic [mtd_pkg::TEXT_W-1:0] tcnt_reg, tcnt_next;
    logic ov_reg, ov_next;
    logic [6:0] code_reg, code_next;
    logic last_reg, last_next;
    logic full;
    logic sp_pend_reg, sp_pend_next;

    assign full = tcnt_reg >= mtd_pkg::TEXT_W'(mtd_pkg::TEXT_LIMIT);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_code = code_reg;
    assign m_last = last_reg;
    assign mac_sel = sel_reg;

    always_comb
    begin
        state_next = state_reg;
        sel_next = sel_reg;
        tcnt_next = tcnt_reg;
        ov_next = ov_reg && !m_tready;
        code_next = code_reg;
        last_next = last_reg;
        sp_pend_next = sp_pend_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd.load_x = 1'b1;
                    if (s_kind)
                    begin
                        cmd.clear = 1'b1;
                        tcnt_next = '0;
                    end
                    else
                    begin
                        sel_next = 2'd0;
                        state_next = S_MAC;
                    end
                end
            end
            S_MAC:
            begin
                cmd.mac = 1'b1;
                sel_next = sel_reg + 2'd1;
                if (sel_reg == 2'd3)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                sp_pend_next = stat.has_space;
                if (stat.has_char && !full)
                    state_next = S_CHAR;
                else if (stat.has_space && !full)
                    state_next = S_SPACE;
                else
                    state_next = S_IDLE;
            end
            S_CHAR:
            begin
                if (!ov_next)
                begin
                    ov_next = 1'b1;
                    code_next = stat.char_code;
                    tcnt_next = tcnt_reg + 1'b1;
                    last_next = !(sp_pend_reg &&
                        (tcnt_reg + 1'b1) < mtd_pkg::TEXT_W'(mtd_pkg::TEXT_LIMIT));
                    state_next = last_next ? S_IDLE : S_SPACE;
                end
            end
            S_SPACE:
            begin
                if (!ov_next)
                begin
                    ov_next = 1'b1;
                    code_next = mtd_pkg::CH_SPACE;
                    tcnt_next = tcnt_reg + 1'b1;
                    last_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg <= '0;
            tcnt_reg <= '0;
            ov_reg <= 1'b0;
            last_reg <= 1'b0;
            sp_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg <= sel_next;
            tcnt_reg <= tcnt_next;
            ov_reg <= ov_next;
            last_reg <= last_next;
            sp_pend_reg <= sp_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_code))
        else $error("output dropped while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == S_IDLE)
        else $error("input taken while busy");
    a_text_cap: assert property (@(posedge clk) disable iff (!rst_n)
        tcnt_reg <= mtd_pkg::TEXT_W'(mtd_pkg::TEXT_LIMIT))
        else $error("text count overflow");

endmodule
